// ----- hdl/dns_query_header_parser_assert.svh -----
// Assertion helpers shared by the checker of the query parser.
// Each use samples on the rising edge of clk and is off while rst_n is low.
`ifndef DNS_QUERY_HEADER_PARSER_ASSERT_SVH
`define DNS_QUERY_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication
`define DQHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define DQHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/dqhp_pkg.sv -----
`timescale 1ns / 1ps

package dqhp_pkg;

  // Name and packet limits
  localparam int unsigned MAX_NAME_LENGTH   = 255;
  localparam int unsigned MIN_PACKET_LENGTH = 17;
  localparam int unsigned HDR_LEN           = 12;
  localparam int unsigned HDR_LAST_POS      = 11;
  localparam logic [15:0] PAD_LIMIT_RESET   = 16'd46;

  // Header flag bits
  localparam logic [15:0] FLAG_KEEP_MASK = 16'h0110;  // RD and CD
  localparam logic [15:0] FLAG_QR        = 16'h8000;
  localparam logic [7:0]  RCODE_MASK     = 8'h0f;
  localparam logic [7:0]  LABEL_PTR_MASK = 8'hc0;
  localparam logic [15:0] QCLASS_IN      = 16'd1;

  // Verdict status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FORMERR = 2'd1;
  localparam logic [1:0] ST_NOTIMP  = 2'd2;

  // Parse phase, one-hot
  typedef enum logic [6:0] {
    PH_HDR   = 7'b0000001,
    PH_LEN   = 7'b0000010,
    PH_LBL   = 7'b0000100,
    PH_TC    = 7'b0001000,
    PH_DONE  = 7'b0010000,
    PH_TRAIL = 7'b0100000,
    PH_BAD   = 7'b1000000
  } dqhp_phase_t;

  // Input item
  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last_byte;
  } dqhp_in_t;

  // Result item
  typedef struct packed {
    logic        drop;
    logic [1:0]  status;
    logic [15:0] query_id;
    logic [15:0] response_flags;
    logic [15:0] question_length;
    logic [7:0]  label_count;
    logic [15:0] last_label_offset;
    logic [5:0]  last_label_length;
    logic [15:0] query_type;
  } dqhp_out_t;

endpackage

// ----- hdl/dns_query_header_parser.sv -----
`timescale 1ns / 1ps

// DNS query header and question checker.
// in_valid/in_stall/in_item carry one packet byte per item; last_byte marks
// the final byte. Exactly one result item leaves on out_valid/out_stall/out_item
// for each packet, built from the state left by its last byte.
// cfg_wr_en/cfg_wr_data write pad_size_limit (reset 46); write it only while idle.
// A last byte passes the input register and then the result register, which
// offers its verdict. Throughput: one byte per cycle unless a last byte waits
// behind a stalled verdict; the per-byte update is a single pass of small logic
// between the input register and the state/result registers.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to the start of a packet and restores the pad limit.
// When the receiver stalls, the verdict holds in the result register; bytes
// that carry no verdict keep flowing, and a further last byte waits in the
// input register, which then stalls the sender.
module dns_query_header_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dqhp_pkg::dqhp_in_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output dqhp_pkg::dqhp_out_t out_item,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  logic               s1_valid_r, s1_valid_nxt;
  dqhp_pkg::dqhp_in_t  s1_item_r;
  logic               s1_adv;
  logic               out_free;
  logic [15:0]        pad_limit_r;
  dqhp_pkg::dqhp_out_t verdict;

  // Pad limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_limit_r <= dqhp_pkg::PAD_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      pad_limit_r <= cfg_wr_data;
    end
  end

  // Input register; a byte without a verdict always moves on
  assign s1_adv       = s1_valid_r && (!s1_item_r.last_byte || out_free);
  assign in_stall     = s1_valid_r && !s1_adv;
  assign s1_valid_nxt = in_stall ? s1_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  dqhp_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (s1_adv),
    .byte_item      (s1_item_r),
    .pad_size_limit (pad_limit_r),
    .verdict        (verdict)
  );

  dqhp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_adv & s1_item_r.last_byte),
    .load_item (verdict),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- hdl/dqhp_parser.sv -----
`timescale 1ns / 1ps

// Running packet state, updated once per taken byte; verdict on the last byte
module dqhp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  dqhp_pkg::dqhp_in_t byte_item,
  input  logic [15:0]       pad_size_limit,
  output dqhp_pkg::dqhp_out_t verdict
);

  logic [15:0]          byte_count_r, byte_count_nxt;
  dqhp_pkg::dqhp_phase_t phase_r, phase_nxt;
  logic [15:0]          id_r, id_nxt;
  logic [15:0]          flags_r, flags_nxt;
  logic                 header_ok_r, header_ok_nxt;
  logic [5:0]           label_rem_r, label_rem_nxt;
  logic [8:0]           name_total_r, name_total_nxt;
  logic [7:0]           labels_seen_r, labels_seen_nxt;
  logic [15:0]          last_label_start_r, last_label_start_nxt;
  logic [15:0]          name_end_pos_r, name_end_pos_nxt;
  logic [31:0]          tc_shift_r, tc_shift_nxt;

  logic [15:0] pos;
  logic [7:0]  b;
  logic [8:0]  name_sum;
  logic [16:0] tc_diff;
  logic        pkt_end;
  logic        too_short;
  logic        q_done;
  logic [1:0]  status;
  logic [15:0] qlen;

  assign pos      = byte_count_r;
  assign b        = byte_item.pkt_byte;
  assign pkt_end  = take & byte_item.last_byte;
  assign name_sum = name_total_r + {1'b0, b} + 9'd1;
  assign tc_diff  = {1'b0, pos} - {1'b0, name_end_pos_r};

  // Per-byte state update
  always_comb begin
    byte_count_nxt       = (byte_count_r != 16'hffff) ? byte_count_r + 16'd1 : byte_count_r;
    phase_nxt            = phase_r;
    id_nxt               = id_r;
    flags_nxt            = flags_r;
    header_ok_nxt        = header_ok_r;
    label_rem_nxt        = label_rem_r;
    name_total_nxt       = name_total_r;
    labels_seen_nxt      = labels_seen_r;
    last_label_start_nxt = last_label_start_r;
    name_end_pos_nxt     = name_end_pos_r;
    tc_shift_nxt         = tc_shift_r;
    unique case (phase_r)
      dqhp_pkg::PH_HDR: begin
        // header phase only sees positions 0 to 11
        case (pos[3:0])
          4'd0: id_nxt[15:8] = b;
          4'd1: id_nxt[7:0]  = b;
          4'd2: flags_nxt[15:8] = b;
          4'd3: begin
            flags_nxt[7:0] = b;
            if ((b & dqhp_pkg::RCODE_MASK) != 8'd0) header_ok_nxt = 1'b0;
          end
          4'd5: if (b != 8'd1) header_ok_nxt = 1'b0;
          4'(dqhp_pkg::HDR_LAST_POS): begin
            if (b > 8'd1) header_ok_nxt = 1'b0;
            phase_nxt            = dqhp_pkg::PH_LEN;
            last_label_start_nxt = 16'(dqhp_pkg::HDR_LEN);
          end
          default: if (b != 8'd0) header_ok_nxt = 1'b0;
        endcase
      end
      dqhp_pkg::PH_LEN: begin
        if (b == 8'd0) begin
          name_end_pos_nxt = pos + 16'd1;
          phase_nxt        = dqhp_pkg::PH_TC;
        end else begin
          labels_seen_nxt      = labels_seen_r + 8'd1;
          last_label_start_nxt = pos + 16'd1;
          if ((b & dqhp_pkg::LABEL_PTR_MASK) != 8'd0) begin
            phase_nxt = dqhp_pkg::PH_BAD;
          end else begin
            name_total_nxt = name_sum;
            if (name_sum > 9'(dqhp_pkg::MAX_NAME_LENGTH)) begin
              phase_nxt = dqhp_pkg::PH_BAD;
            end else begin
              label_rem_nxt = b[5:0];
              phase_nxt     = dqhp_pkg::PH_LBL;
            end
          end
        end
      end
      dqhp_pkg::PH_LBL: begin
        label_rem_nxt = label_rem_r - 6'd1;
        if (label_rem_r == 6'd1) phase_nxt = dqhp_pkg::PH_LEN;
      end
      dqhp_pkg::PH_TC: begin
        tc_shift_nxt = {tc_shift_r[23:0], b};
        // count saturation can leave pos behind the name end
        if (tc_diff[16] || (tc_diff[15:0] >= 16'd3)) phase_nxt = dqhp_pkg::PH_DONE;
      end
      dqhp_pkg::PH_DONE: phase_nxt = dqhp_pkg::PH_TRAIL;
      default: phase_nxt = phase_r;
    endcase
  end

  // Verdict from the state after the last byte
  assign too_short = (byte_count_nxt < 16'(dqhp_pkg::HDR_LEN)) ||
                     (byte_count_nxt < 16'(dqhp_pkg::MIN_PACKET_LENGTH)) ||
                     ((flags_nxt & dqhp_pkg::FLAG_QR) != 16'd0);
  assign q_done    = (phase_nxt == dqhp_pkg::PH_DONE) || (phase_nxt == dqhp_pkg::PH_TRAIL);

  always_comb begin
    status = dqhp_pkg::ST_OK;
    qlen   = 16'd0;
    if (!header_ok_nxt) begin
      status = dqhp_pkg::ST_FORMERR;
    end else if (flags_nxt[14:11] != 4'd0) begin
      status = dqhp_pkg::ST_NOTIMP;
    end else if (q_done) begin
      qlen = name_end_pos_nxt + 16'd4 - 16'(dqhp_pkg::HDR_LEN);
      if (tc_shift_nxt[15:0] != dqhp_pkg::QCLASS_IN) begin
        status = dqhp_pkg::ST_NOTIMP;
      end else if ((phase_nxt == dqhp_pkg::PH_TRAIL) && (byte_count_nxt > pad_size_limit)) begin
        status = dqhp_pkg::ST_FORMERR;
      end
    end else begin
      status = dqhp_pkg::ST_FORMERR;
    end
  end

  always_comb begin
    verdict      = '0;
    verdict.drop = too_short;
    if (!too_short) begin
      verdict.status          = status;
      verdict.query_id        = id_nxt;
      verdict.response_flags  = (flags_nxt & dqhp_pkg::FLAG_KEEP_MASK) |
                                dqhp_pkg::FLAG_QR | {14'd0, status};
      verdict.question_length = qlen;
      if (qlen != 16'd0) begin
        verdict.label_count       = labels_seen_nxt;
        verdict.last_label_offset = last_label_start_nxt;
        verdict.last_label_length = 6'(name_end_pos_nxt - last_label_start_nxt - 16'd1);
        verdict.query_type        = tc_shift_nxt[31:16];
      end
    end
  end

  // State registers, cleared at reset and after each packet
  always_ff @(posedge clk) begin
    if (!rst_n || pkt_end) begin
      byte_count_r       <= '0;
      phase_r            <= dqhp_pkg::PH_HDR;
      id_r               <= '0;
      flags_r            <= '0;
      header_ok_r        <= 1'b1;
      label_rem_r        <= '0;
      name_total_r       <= '0;
      labels_seen_r      <= '0;
      last_label_start_r <= '0;
      name_end_pos_r     <= '0;
      tc_shift_r         <= '0;
    end else if (take) begin
      byte_count_r       <= byte_count_nxt;
      phase_r            <= phase_nxt;
      id_r               <= id_nxt;
      flags_r            <= flags_nxt;
      header_ok_r        <= header_ok_nxt;
      label_rem_r        <= label_rem_nxt;
      name_total_r       <= name_total_nxt;
      labels_seen_r      <= labels_seen_nxt;
      last_label_start_r <= last_label_start_nxt;
      name_end_pos_r     <= name_end_pos_nxt;
      tc_shift_r         <= tc_shift_nxt;
    end
  end

endmodule

// ----- hdl/dqhp_out_reg.sv -----
`timescale 1ns / 1ps

// Result register: holds one verdict until the receiver takes it
module dqhp_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  dqhp_pkg::dqhp_out_t load_item,
  input  logic               out_stall,
  output logic               free,
  output logic               out_valid,
  output dqhp_pkg::dqhp_out_t out_item
);

  logic               out_valid_r, out_valid_nxt;
  dqhp_pkg::dqhp_out_t out_item_r;

  // free when empty or being taken this cycle
  assign free          = !out_valid_r || !out_stall;
  assign out_valid_nxt = load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= load_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- hdl/dqhp_checker.sv -----
`timescale 1ns / 1ps

`include "dns_query_header_parser_assert.svh"

// Port-level checks on the query parser
module dqhp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input dqhp_pkg::dqhp_out_t out_item
);

  // a stalled verdict stays offered and unchanged
  `DQHP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "verdict dropped or changed while stalled")

  // dropped packets carry nothing but the drop flag
  `DQHP_ASSERT_NOW(a_drop_clean, out_valid && out_item.drop, (out_item.status == dqhp_pkg::ST_OK) && (out_item.query_id == 16'd0) && (out_item.response_flags == 16'd0) && (out_item.question_length == 16'd0), "dropped verdict has non-zero fields")

  // status is a defined code and sits in the rcode bits
  `DQHP_ASSERT_NOW(a_status_rcode, out_valid && !out_item.drop, (out_item.status != 2'd3) && (out_item.response_flags[3:0] == {2'b00, out_item.status}) && out_item.response_flags[15], "status and response flags disagree")

  // question details only with a question
  `DQHP_ASSERT_NOW(a_no_question, out_valid && (out_item.question_length == 16'd0), (out_item.label_count == 8'd0) && (out_item.query_type == 16'd0) && (out_item.last_label_offset == 16'd0), "question fields set without a question")

  // the sender is only held back behind a stalled verdict
  `DQHP_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled with no stalled verdict")

endmodule

bind dns_query_header_parser dqhp_checker u_dqhp_checker (.*);
